FILE: design/bcr_pkg.sv
// Package for the dual-rate bitcrusher: payload types, config struct,
// sequencer states and fixed-point constants. No dependencies.
package bcr_pkg;

  typedef struct packed {
    logic signed [23:0] sample_in;
    logic               block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] sample_out;
    logic               block_end_out;
  } out_item_t;

  typedef struct packed {
    logic [20:0] input_gain;
    logic [20:0] output_gain;
    logic [16:0] wet_mix;
    logic [23:0] phase_step_raw;
    logic [23:0] phase_step_interp;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_INPUT_GAIN   = 3'd0,
    REG_OUTPUT_GAIN  = 3'd1,
    REG_WET_MIX      = 3'd2,
    REG_STEP_RAW     = 3'd3,
    REG_STEP_INTERP  = 3'd4
  } reg_idx_t;

  // operands of the shared multiplier
  typedef struct packed {
    logic [34:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef enum logic [5:0] {
    S_IDLE, S_GAIN, S_CLIP, S_SCALE, S_ABS, S_SQ, S_A, S_A2, S_A2R,
    S_HT, S_HD, S_HM, S_HQ, S_SH, S_SHR,
    S_PH, S_HV, S_HR, S_QD, S_QM, S_QQ, S_QR, S_QS, S_QT, S_QF,
    S_D1, S_D2, S_D3, S_G, S_GR, S_W1, S_W2, S_W3, S_OUT
  } state_t;

  localparam logic [28:0] Q_ONE    = 29'd268435456;
  localparam logic [28:0] SHAPE_K  = 29'd336433952;
  localparam logic [19:0] REZ_A    = 20'd447392;
  localparam logic [19:0] REZ_B    = 20'd715828;
  localparam logic [24:0] PH_ONE   = 25'd16777216;
  localparam logic [16:0] WET_ONE  = 17'd65536;
  localparam logic [17:0] WET_TWO  = 18'd131072;

  // Reciprocals ceil(2^k/d), exact floor division for dividends below 2^30
  localparam logic [30:0] HORN_M0 = 31'(((64'd1 << 37) + 64'd109) / 64'd110);
  localparam logic [30:0] HORN_M1 = 31'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [30:0] HORN_M2 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [30:0] HORN_M3 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [30:0] HORN_M4 = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [30:0] REZ_A_M = 31'(((64'd1 << 49) + 64'd447391) / 64'd447392);
  localparam logic [30:0] REZ_B_M = 31'(((64'd1 << 50) + 64'd715827) / 64'd715828);

endpackage

FILE: design/dual_rate_bitcrusher_unit.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    bcr_pkg::in_item_t
// out_      output     out_valid/out_ready  bcr_pkg::out_item_t
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The time from acceptance to result is set by the multiplier sequence in
// bcr_core: it grows for each path that takes a hold and when wet is below
// unity. The next item is taken at the earliest once the sequencer is back
// in idle after the result has left it.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the sequencer until the output register is free, stalling the input.
// rst_n (synchronous) restores config defaults and clears all filter state.
// Top level: config registers and output register. Depends on bcr_pkg,
// bcr_core.
module dual_rate_bitcrusher_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bcr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bcr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  bcr_pkg::cfg_t      cfg_r;
  bcr_pkg::out_item_t res, out_data_r;
  logic               out_valid_r, idle, res_valid, out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bcr_core u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .start(in_valid && idle), .item(in_data), .out_free(out_free),
    .idle(idle), .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_gain        <= 21'd65536;
      cfg_r.output_gain       <= 21'd65536;
      cfg_r.wet_mix           <= 17'd65536;
      cfg_r.phase_step_raw    <= 24'd5592405;
      cfg_r.phase_step_interp <= 24'd9048557;
    end else if (cfg_valid) begin
      case (cfg_index)
        bcr_pkg::REG_INPUT_GAIN:  cfg_r.input_gain        <= cfg_data[20:0];
        bcr_pkg::REG_OUTPUT_GAIN: cfg_r.output_gain       <= cfg_data[20:0];
        bcr_pkg::REG_WET_MIX:     cfg_r.wet_mix           <= cfg_data[16:0];
        bcr_pkg::REG_STEP_RAW:    cfg_r.phase_step_raw    <= cfg_data;
        bcr_pkg::REG_STEP_INTERP: cfg_r.phase_step_interp <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) out_data_r <= res;
  end

endmodule

FILE: design/bcr_mul.sv
// Shared signed multiplier with registered product.
// Depends on bcr_pkg (mul_req_t).
module bcr_mul (
  input  logic               clk,
  input  bcr_pkg::mul_req_t  req,
  output logic signed [66:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= 67'($signed(req.a)) * 67'($signed(req.b));
  end

endmodule

FILE: design/bcr_core.sv
// Sequencer and datapath: shaping, two hold paths, blend and mix, all
// through one shared multiplier. Depends on bcr_pkg and bcr_mul.
module bcr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  bcr_pkg::cfg_t     cfg,
  input  logic              start,
  input  bcr_pkg::in_item_t item,
  input  logic              out_free,
  output logic              idle,
  output logic              res_valid,
  output bcr_pkg::out_item_t res
);

  bcr_pkg::state_t   state_r, state_nxt;
  bcr_pkg::mul_req_t mreq;
  logic signed [66:0] prod;

  logic [2:0]  hidx_r, hidx_nxt;
  logic        path_r, path_nxt;
  logic signed [23:0] s_r, s_nxt;
  logic        be_r, be_nxt;
  logic signed [29:0] x_r, x_nxt;
  logic [28:0] m_r, m_nxt;
  logic        neg_r, neg_nxt;
  logic [28:0] a_r, a_nxt;
  logic [29:0] a2_r, a2_nxt;
  logic [28:0] t_r, t_nxt;
  logic [29:0] n_r, n_nxt;
  logic signed [31:0] shaped_r, shaped_nxt, half_r, half_nxt;
  logic signed [31:0] prev_shaped_r, prev_shaped_nxt;
  logic [24:0] phase_a_r, phase_a_nxt, phase_b_r, phase_b_nxt;
  logic signed [31:0] held_a_r, held_a_nxt, held_b_r, held_b_nxt;
  logic signed [31:0] out_r, out_nxt;
  logic [29:0] nq_r, nq_nxt;
  logic        negp_r, negp_nxt;
  logic [11:0] q_r, q_nxt;
  logic [29:0] m2_r, m2_nxt;
  logic signed [31:0] pa_r, pa_nxt, blend_r, blend_nxt;
  logic signed [31:0] prev_blend_r, prev_blend_nxt;
  logic signed [51:0] acc_r, acc_nxt;
  logic signed [34:0] d_r, d_nxt;

  logic [16:0] wet;
  logic [24:0] step_sel, phase_sel;
  logic [25:0] ph_sum;
  logic [19:0] rez;
  logic [30:0] rez_m;
  logic signed [31:0] v_sel, held_sel, held_new, mag, pv;
  logic signed [32:0] sum33;
  logic signed [55:0] xg;
  logic signed [29:0] x2, r30;
  logic [29:0] rr, m3;
  logic [27:0] quo;
  logic signed [52:0] sum53;

  bcr_mul u_mul (.clk(clk), .req(mreq), .prod_r(prod));

  assign wet       = (cfg.wet_mix > bcr_pkg::WET_ONE) ? bcr_pkg::WET_ONE : cfg.wet_mix;
  assign step_sel  = path_r ? {1'b0, cfg.phase_step_interp} : {1'b0, cfg.phase_step_raw};
  assign phase_sel = path_r ? phase_b_r : phase_a_r;
  assign v_sel     = path_r ? half_r : shaped_r;
  assign held_sel  = path_r ? held_b_r : held_a_r;
  assign rez       = path_r ? bcr_pkg::REZ_B : bcr_pkg::REZ_A;
  assign rez_m     = path_r ? bcr_pkg::REZ_B_M : bcr_pkg::REZ_A_M;
  assign idle      = (state_r == bcr_pkg::S_IDLE);
  assign res_valid = (state_r == bcr_pkg::S_OUT);

  always_comb begin
    r30 = 30'(d_r >>> 5);
    if (r30 > 30'sd8388607) begin
      res.sample_out = 24'sd8388607;
    end else if (r30 < -30'sd8388608) begin
      res.sample_out = -24'sd8388608;
    end else begin
      res.sample_out = r30[23:0];
    end
    res.block_end_out = be_r;
  end

  always_comb begin
    state_nxt = state_r;
    hidx_nxt = hidx_r; path_nxt = path_r; s_nxt = s_r; be_nxt = be_r;
    x_nxt = x_r; m_nxt = m_r; neg_nxt = neg_r; a_nxt = a_r; a2_nxt = a2_r;
    t_nxt = t_r; n_nxt = n_r; shaped_nxt = shaped_r; half_nxt = half_r;
    prev_shaped_nxt = prev_shaped_r; phase_a_nxt = phase_a_r;
    phase_b_nxt = phase_b_r; held_a_nxt = held_a_r; held_b_nxt = held_b_r;
    out_nxt = out_r; nq_nxt = nq_r; negp_nxt = negp_r; q_nxt = q_r;
    m2_nxt = m2_r; pa_nxt = pa_r; blend_nxt = blend_r;
    prev_blend_nxt = prev_blend_r; acc_nxt = acc_r; d_nxt = d_r;
    mreq = '0;
    ph_sum = {1'b0, phase_sel} + {1'b0, step_sel};
    xg = 56'(prod >>> 11);
    x2 = 30'(prod >>> 28);
    rr = prod[57:28];
    held_new = 32'(prod >>> 24);
    sum33 = {out_r[31], out_r} + {held_new[31], held_new};
    mag = out_r[31] ? -out_r : out_r;
    m3 = prod[57:28];
    pv = '0;
    quo = '0;
    sum53 = '0;
    case (state_r)
      bcr_pkg::S_IDLE: begin
        if (start) begin
          s_nxt = item.sample_in;
          be_nxt = item.block_end;
          state_nxt = bcr_pkg::S_GAIN;
        end
      end
      bcr_pkg::S_GAIN: begin
        mreq.a = 35'(s_r);
        mreq.b = {11'b0, cfg.input_gain};
        state_nxt = bcr_pkg::S_CLIP;
      end
      bcr_pkg::S_CLIP: begin
        if (xg > 56'sd268435456) begin
          x_nxt = 30'sd268435456;
        end else if (xg < -56'sd268435456) begin
          x_nxt = -30'sd268435456;
        end else begin
          x_nxt = xg[29:0];
        end
        state_nxt = bcr_pkg::S_SCALE;
      end
      bcr_pkg::S_SCALE: begin
        mreq.a = 35'(x_r);
        mreq.b = {3'b0, bcr_pkg::SHAPE_K};
        state_nxt = bcr_pkg::S_ABS;
      end
      bcr_pkg::S_ABS: begin
        neg_nxt = x2[29];
        m_nxt = x2[29] ? 29'(-x2) : x2[28:0];
        state_nxt = bcr_pkg::S_SQ;
      end
      bcr_pkg::S_SQ: begin
        mreq.a = {6'b0, m_r};
        mreq.b = {3'b0, m_r};
        state_nxt = bcr_pkg::S_A;
      end
      bcr_pkg::S_A: begin
        a_nxt = prod[56:28];
        state_nxt = bcr_pkg::S_A2;
      end
      bcr_pkg::S_A2: begin
        mreq.a = {6'b0, a_r};
        mreq.b = {3'b0, a_r};
        state_nxt = bcr_pkg::S_A2R;
      end
      bcr_pkg::S_A2R: begin
        a2_nxt = prod[57:28];
        t_nxt = bcr_pkg::Q_ONE;
        hidx_nxt = '0;
        state_nxt = bcr_pkg::S_HT;
      end
      // Horner step: t = 1 - ((a2*t)>>28)/div
      bcr_pkg::S_HT: begin
        mreq.a = {5'b0, a2_r};
        mreq.b = {3'b0, t_r};
        state_nxt = bcr_pkg::S_HD;
      end
      bcr_pkg::S_HD: begin
        n_nxt = prod[57:28];
        state_nxt = bcr_pkg::S_HM;
      end
      bcr_pkg::S_HM: begin
        mreq.a = {5'b0, n_r};
        case (hidx_r)
          3'd0:    mreq.b = {1'b0, bcr_pkg::HORN_M0};
          3'd1:    mreq.b = {1'b0, bcr_pkg::HORN_M1};
          3'd2:    mreq.b = {1'b0, bcr_pkg::HORN_M2};
          3'd3:    mreq.b = {1'b0, bcr_pkg::HORN_M3};
          default: mreq.b = {1'b0, bcr_pkg::HORN_M4};
        endcase
        state_nxt = bcr_pkg::S_HQ;
      end
      bcr_pkg::S_HQ: begin
        case (hidx_r)
          3'd0, 3'd1: quo = prod[64:37];
          3'd2:       quo = prod[63:36];
          3'd3:       quo = prod[62:35];
          default:    quo = prod[60:33];
        endcase
        t_nxt = bcr_pkg::Q_ONE - {1'b0, quo};
        if (hidx_r == 3'd4) begin
          state_nxt = bcr_pkg::S_SH;
        end else begin
          hidx_nxt = hidx_r + 3'd1;
          state_nxt = bcr_pkg::S_HT;
        end
      end
      bcr_pkg::S_SH: begin
        mreq.a = {6'b0, m_r};
        mreq.b = {3'b0, t_r};
        state_nxt = bcr_pkg::S_SHR;
      end
      bcr_pkg::S_SHR: begin
        shaped_nxt = neg_r ? -32'(rr) : 32'(rr);
        sum33 = {shaped_nxt[31], shaped_nxt} + {prev_shaped_r[31], prev_shaped_r};
        half_nxt = sum33[32:1];
        prev_shaped_nxt = shaped_nxt;
        path_nxt = 1'b0;
        state_nxt = bcr_pkg::S_PH;
      end
      // hold paths, raw path first
      bcr_pkg::S_PH: begin
        out_nxt = held_sel;
        if (ph_sum > {1'b0, bcr_pkg::PH_ONE}) begin
          ph_sum = ph_sum - {1'b0, bcr_pkg::PH_ONE};
          state_nxt = bcr_pkg::S_HV;
        end else begin
          state_nxt = bcr_pkg::S_QD;
        end
        if (path_r) phase_b_nxt = ph_sum[24:0];
        else        phase_a_nxt = ph_sum[24:0];
      end
      bcr_pkg::S_HV: begin
        mreq.a = 35'(v_sel);
        mreq.b = 32'(bcr_pkg::PH_ONE - phase_sel);
        state_nxt = bcr_pkg::S_HR;
      end
      bcr_pkg::S_HR: begin
        if (path_r) held_b_nxt = held_new;
        else        held_a_nxt = held_new;
        out_nxt = sum33[32:1];
        state_nxt = bcr_pkg::S_QD;
      end
      bcr_pkg::S_QD: begin
        negp_nxt = out_r[31];
        nq_nxt = 30'(mag + 32'(rez) - 32'd1);
        state_nxt = bcr_pkg::S_QM;
      end
      bcr_pkg::S_QM: begin
        mreq.a = {5'b0, nq_r};
        mreq.b = {1'b0, rez_m};
        state_nxt = bcr_pkg::S_QQ;
      end
      bcr_pkg::S_QQ: begin
        q_nxt = path_r ? prod[61:50] : prod[60:49];
        state_nxt = bcr_pkg::S_QR;
      end
      bcr_pkg::S_QR: begin
        mreq.a = {23'b0, q_r};
        mreq.b = {12'b0, rez};
        state_nxt = bcr_pkg::S_QS;
      end
      bcr_pkg::S_QS: begin
        m2_nxt = prod[29:0];
        state_nxt = bcr_pkg::S_QT;
      end
      bcr_pkg::S_QT: begin
        mreq.a = {5'b0, m2_r};
        mreq.b = {3'b0, bcr_pkg::Q_ONE - 29'(rez)};
        state_nxt = bcr_pkg::S_QF;
      end
      bcr_pkg::S_QF: begin
        if (m3 < 30'(rez)) begin
          pv = '0;
        end else begin
          pv = negp_r ? -32'(m3) : 32'(m3);
        end
        if (!path_r) begin
          pa_nxt = pv;
          path_nxt = 1'b1;
          state_nxt = bcr_pkg::S_PH;
        end else begin
          sum33 = {pa_r[31], pa_r} + {pv[31], pv};
          blend_nxt = sum33[32:1];
          state_nxt = bcr_pkg::S_D1;
        end
      end
      bcr_pkg::S_D1: begin
        mreq.a = 35'(blend_r);
        mreq.b = 32'(bcr_pkg::WET_TWO - 18'(wet));
        state_nxt = bcr_pkg::S_D2;
      end
      bcr_pkg::S_D2: begin
        acc_nxt = 52'(prod);
        mreq.a = 35'(prev_blend_r);
        mreq.b = 32'(wet);
        prev_blend_nxt = blend_r;
        state_nxt = bcr_pkg::S_D3;
      end
      bcr_pkg::S_D3: begin
        sum53 = 53'(acc_r) + 53'(prod);
        d_nxt = 35'(sum53 >>> 17);
        state_nxt = bcr_pkg::S_G;
      end
      bcr_pkg::S_G: begin
        mreq.a = d_r;
        mreq.b = {11'b0, cfg.output_gain};
        state_nxt = bcr_pkg::S_GR;
      end
      bcr_pkg::S_GR: begin
        d_nxt = 35'(prod >>> 16);
        state_nxt = (wet < bcr_pkg::WET_ONE) ? bcr_pkg::S_W1 : bcr_pkg::S_OUT;
      end
      // dry/wet mix; dry is the sample times 32
      bcr_pkg::S_W1: begin
        mreq.a = 35'(s_r);
        mreq.b = 32'(bcr_pkg::WET_ONE - wet);
        state_nxt = bcr_pkg::S_W2;
      end
      bcr_pkg::S_W2: begin
        acc_nxt = 52'(prod) <<< 5;
        mreq.a = d_r;
        mreq.b = 32'(wet);
        state_nxt = bcr_pkg::S_W3;
      end
      bcr_pkg::S_W3: begin
        sum53 = 53'(acc_r) + 53'(prod);
        d_nxt = 35'(sum53 >>> 16);
        state_nxt = bcr_pkg::S_OUT;
      end
      bcr_pkg::S_OUT: begin
        if (out_free) state_nxt = bcr_pkg::S_IDLE;
      end
      default: state_nxt = bcr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcr_pkg::S_IDLE;
      prev_shaped_r <= '0;
      phase_a_r <= '0;
      phase_b_r <= '0;
      held_a_r <= '0;
      held_b_r <= '0;
      prev_blend_r <= '0;
    end else begin
      state_r <= state_nxt;
      prev_shaped_r <= prev_shaped_nxt;
      phase_a_r <= phase_a_nxt;
      phase_b_r <= phase_b_nxt;
      held_a_r <= held_a_nxt;
      held_b_r <= held_b_nxt;
      prev_blend_r <= prev_blend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hidx_r <= hidx_nxt; path_r <= path_nxt; s_r <= s_nxt; be_r <= be_nxt;
    x_r <= x_nxt; m_r <= m_nxt; neg_r <= neg_nxt; a_r <= a_nxt; a2_r <= a2_nxt;
    t_r <= t_nxt; n_r <= n_nxt; shaped_r <= shaped_nxt; half_r <= half_nxt;
    out_r <= out_nxt; nq_r <= nq_nxt; negp_r <= negp_nxt; q_r <= q_nxt;
    m2_r <= m2_nxt; pa_r <= pa_nxt; blend_r <= blend_nxt;
    acc_r <= acc_nxt; d_r <= d_nxt;
  end

endmodule
